// ===== hdl/itcs_pkg.sv =====
`default_nettype none

package itcs_pkg;

  // Defaults for the top-level parameters.
  localparam int CHALLENGE_BYTES_DFLT = 32;
  localparam int RESPONSE_BYTES_DFLT  = 20;
  localparam int CONNECT_BYTES_DFLT   = 8;
  localparam int POLL_LIMIT_DFLT      = 15;
  localparam int QUEUE_DEPTH_DFLT     = 2;

  // Result counter width; covers the largest poll limit of 63.
  localparam int CNT_W = 6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0] PRIME_STEP   = 16'd38543;
  localparam logic [11:0] ACCEPT_BYTES = 12'd4;
  localparam logic [31:0] NO_ADDRESS   = 32'hffff_ffff;

  // Commands.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_RECV  = 2'd1;
  localparam logic [1:0] CMD_TIMER = 2'd2;
  localparam logic [1:0] CMD_DATA  = 2'd3;

  // Received packet types.
  localparam logic [2:0] PT_RESET     = 3'd0;
  localparam logic [2:0] PT_FULL      = 3'd1;
  localparam logic [2:0] PT_CHALLENGE = 3'd2;
  localparam logic [2:0] PT_ACCEPT    = 3'd3;
  localparam logic [2:0] PT_CHAL_ERR  = 3'd4;
  localparam logic [2:0] PT_DATA      = 3'd5;

  // Message types to send.
  localparam logic [2:0] SEND_NONE     = 3'd0;
  localparam logic [2:0] SEND_REQUEST  = 3'd1;
  localparam logic [2:0] SEND_RESPONSE = 3'd2;
  localparam logic [2:0] SEND_POLL     = 3'd3;
  localparam logic [2:0] SEND_DATA     = 3'd4;

  // Timer requests.
  localparam logic [1:0] TMR_NONE      = 2'd0;
  localparam logic [1:0] TMR_HANDSHAKE = 2'd1;
  localparam logic [1:0] TMR_KEEPALIVE = 2'd2;
  localparam logic [1:0] TMR_POLL      = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_SERVER_FULL  = 3'd1;
  localparam logic [2:0] ERR_BAD_CHAL     = 3'd2;
  localparam logic [2:0] ERR_BAD_ADDRESS  = 3'd3;
  localparam logic [2:0] ERR_PASSWORD     = 3'd4;
  localparam logic [2:0] ERR_ADDR_REFUSED = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SERVER_ADDRESS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DESIRED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_COUNT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_IDENTIFIER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SEQUENCE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IDENTIFIER_START = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_START  = 3'd6;

  typedef struct packed {
    logic [31:0] server_address;
    logic [31:0] initial_desired_address;
    logic [3:0]  poll_count;
    logic        step_identifier;
    logic        step_sequence;
    logic [15:0] identifier_start;
    logic [15:0] sequence_start;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] source_address;
    logic        is_reply;
    logic        magic_ok;
    logic [2:0]  packet_type;
    logic [11:0] data_length;
    logic [31:0] payload_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  send_type;
    logic [11:0] send_length;
    logic [15:0] echo_identifier;
    logic [15:0] echo_sequence;
    logic [1:0]  timer_request;
    logic [11:0] deliver_length;
    logic        accepted;
    logic [2:0]  error_code;
    logic [31:0] address_value;
    logic        address_changed;
    logic        last;
  } out_item_t;

  // Work for the back end: what one event sends and reports.
  typedef struct packed {
    logic [2:0]       send_type;
    logic [11:0]      send_length;
    logic [CNT_W-1:0] count;
    logic [31:0]      first_addr;
    logic [11:0]      deliver_length;
    logic             accepted;
    logic [2:0]       error_code;
    logic             address_changed;
    logic [1:0]       timer_request;
    logic             load_ids;
  } desc_t;

endpackage

`default_nettype wire

// ===== hdl/itcs_queue.sv =====
`default_nettype none

module itcs_queue #(
  parameter int DEPTH = itcs_pkg::QUEUE_DEPTH_DFLT
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire itcs_pkg::desc_t din,
  output logic                 full,
  input  wire logic            pop,
  output itcs_pkg::desc_t      dout,
  output logic                 empty
);

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTQ_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNTQ_W-1:0] FULL_CNT = CNTQ_W'(DEPTH);

  itcs_pkg::desc_t   entries_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNTQ_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign dout    = entries_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue holds more entries than its depth");

  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not follow a push");

  a_cnt_dec: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop && !do_push |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("queue count did not follow a pop");
`endif

endmodule

`default_nettype wire

// ===== hdl/itcs_front.sv =====
`default_nettype none

module itcs_front #(
  parameter int CHALLENGE_BYTES = itcs_pkg::CHALLENGE_BYTES_DFLT,
  parameter int RESPONSE_BYTES  = itcs_pkg::RESPONSE_BYTES_DFLT,
  parameter int CONNECT_BYTES   = itcs_pkg::CONNECT_BYTES_DFLT,
  parameter int POLL_LIMIT      = itcs_pkg::POLL_LIMIT_DFLT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire itcs_pkg::cfg_t     cfg,
  input  wire logic               in_push,
  input  wire itcs_pkg::in_item_t in_item,
  output logic                    in_full,
  output logic                    q_push,
  output itcs_pkg::desc_t         q_desc,
  input  wire logic               q_full
);

  localparam int CW = itcs_pkg::CNT_W;
  localparam logic [CW-1:0] ONE_SEND  = CW'(1);
  localparam logic [CW-1:0] LIMIT     = CW'(POLL_LIMIT);
  localparam logic [11:0]   CHAL_LEN  = 12'(CHALLENGE_BYTES);
  localparam logic [11:0]   RESP_LEN  = 12'(RESPONSE_BYTES);
  localparam logic [11:0]   CONN_LEN  = 12'(CONNECT_BYTES);

  typedef enum logic [1:0] {
    ST_CLOSED,
    ST_REQ,
    ST_RESP,
    ST_EST
  } sess_t;

  sess_t       state_r, state_nxt;
  logic [31:0] client_r, client_nxt;
  logic [31:0] wanted_r, wanted_nxt;
  logic        priv_r, priv_nxt;

  logic [CW-1:0]   poll_ext;
  logic [CW-1:0]   poll_n;
  logic            from_server;
  logic            keepalive;
  logic            do_req;
  logic [31:0]     req_addr;
  itcs_pkg::desc_t desc;

  assign poll_ext    = CW'(cfg.poll_count);
  assign poll_n      = (poll_ext < LIMIT) ? poll_ext : LIMIT;
  assign keepalive   = (cfg.poll_count == 4'd0);
  assign from_server = (in_item.source_address == cfg.server_address) &&
                       in_item.is_reply && in_item.magic_ok;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;
  assign q_desc  = desc;

  always_comb begin
    state_nxt  = state_r;
    client_nxt = client_r;
    wanted_nxt = wanted_r;
    priv_nxt   = priv_r;
    desc       = '0;
    do_req     = 1'b0;
    req_addr   = wanted_r;

    unique case (in_item.command)
      itcs_pkg::CMD_START: begin
        wanted_nxt    = cfg.initial_desired_address;
        req_addr      = cfg.initial_desired_address;
        desc.load_ids = 1'b1;
        do_req        = 1'b1;
      end
      itcs_pkg::CMD_RECV: begin
        if (from_server) begin
          desc.accepted = 1'b1;
          unique case (in_item.packet_type)
            itcs_pkg::PT_RESET: begin
              do_req = 1'b1;
            end
            itcs_pkg::PT_FULL: begin
              if (state_r == ST_REQ) begin
                desc.error_code = itcs_pkg::ERR_SERVER_FULL;
                state_nxt       = ST_CLOSED;
              end
            end
            itcs_pkg::PT_CHALLENGE: begin
              if (state_r == ST_REQ) begin
                if (in_item.data_length != CHAL_LEN) begin
                  desc.error_code = itcs_pkg::ERR_BAD_CHAL;
                  state_nxt       = ST_CLOSED;
                end else begin
                  state_nxt          = ST_RESP;
                  desc.send_type     = itcs_pkg::SEND_RESPONSE;
                  desc.send_length   = RESP_LEN;
                  desc.count         = ONE_SEND;
                  desc.timer_request = itcs_pkg::TMR_HANDSHAKE;
                end
              end
            end
            itcs_pkg::PT_ACCEPT: begin
              if (state_r == ST_RESP) begin
                if (in_item.data_length != itcs_pkg::ACCEPT_BYTES) begin
                  desc.error_code = itcs_pkg::ERR_BAD_ADDRESS;
                  state_nxt       = ST_CLOSED;
                end else if (in_item.payload_address != client_r && priv_r) begin
                  desc.error_code = itcs_pkg::ERR_ADDR_REFUSED;
                  state_nxt       = ST_CLOSED;
                end else begin
                  if (in_item.payload_address != client_r) begin
                    client_nxt           = in_item.payload_address;
                    wanted_nxt           = in_item.payload_address;
                    desc.address_changed = 1'b1;
                    desc.first_addr      = in_item.payload_address;
                  end
                  state_nxt = ST_EST;
                  priv_nxt  = 1'b1;
                  if (keepalive) begin
                    desc.timer_request = itcs_pkg::TMR_KEEPALIVE;
                  end else begin
                    desc.send_type     = itcs_pkg::SEND_POLL;
                    desc.count         = poll_n;
                    desc.timer_request = itcs_pkg::TMR_POLL;
                  end
                end
              end
            end
            itcs_pkg::PT_CHAL_ERR: begin
              if (state_r == ST_RESP) begin
                desc.error_code = itcs_pkg::ERR_PASSWORD;
                state_nxt       = ST_CLOSED;
              end
            end
            itcs_pkg::PT_DATA: begin
              if (state_r == ST_EST && in_item.data_length != 12'd0) begin
                desc.deliver_length = in_item.data_length;
                // In poll mode every delivered packet is answered by a fresh poll.
                if (!keepalive) begin
                  desc.send_type = itcs_pkg::SEND_POLL;
                  desc.count     = ONE_SEND;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      itcs_pkg::CMD_TIMER: begin
        if (state_r == ST_REQ || state_r == ST_RESP) begin
          do_req = 1'b1;
        end else if (state_r == ST_EST) begin
          desc.send_type     = itcs_pkg::SEND_POLL;
          desc.count         = ONE_SEND;
          desc.timer_request = keepalive ? itcs_pkg::TMR_KEEPALIVE : itcs_pkg::TMR_POLL;
        end
      end
      itcs_pkg::CMD_DATA: begin
        if (state_r == ST_EST) begin
          desc.send_type     = itcs_pkg::SEND_DATA;
          desc.send_length   = in_item.data_length;
          desc.count         = ONE_SEND;
          desc.timer_request = keepalive ? itcs_pkg::TMR_KEEPALIVE : itcs_pkg::TMR_NONE;
        end
      end
      default: begin
      end
    endcase

    if (do_req) begin
      desc.send_type     = itcs_pkg::SEND_REQUEST;
      desc.send_length   = CONN_LEN;
      desc.count         = ONE_SEND;
      desc.first_addr    = req_addr;
      desc.timer_request = itcs_pkg::TMR_HANDSHAKE;
      state_nxt          = ST_REQ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLOSED;
      client_r <= itcs_pkg::NO_ADDRESS;
      wanted_r <= '0;
      priv_r   <= 1'b0;
    end else if (q_push) begin
      state_r  <= state_nxt;
      client_r <= client_nxt;
      wanted_r <= wanted_nxt;
      priv_r   <= priv_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/itcs_back.sv =====
`default_nettype none

module itcs_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire itcs_pkg::cfg_t  cfg,
  input  wire logic            q_empty,
  input  wire itcs_pkg::desc_t q_desc,
  output logic                 q_pop,
  output itcs_pkg::out_item_t  out_item,
  output logic                 out_empty,
  input  wire logic            out_pop
);

  localparam int CW = itcs_pkg::CNT_W;

  itcs_pkg::desc_t     desc_r;
  logic                busy_r;
  logic [CW-1:0]       idx_r;
  logic [15:0]         id_r;
  logic [15:0]         seq_r;
  itcs_pkg::out_item_t out_item_r;
  logic                out_valid_r;

  logic                sending;
  logic                first;
  logic                final_res;
  logic                emit;
  logic                taken;
  itcs_pkg::out_item_t res;

  assign q_pop     = !busy_r && !q_empty;
  assign taken     = out_pop && out_valid_r;
  assign emit      = busy_r && (!out_valid_r || out_pop);
  assign out_item  = out_item_r;
  assign out_empty = !out_valid_r;

  assign sending   = (desc_r.count != '0);
  assign first     = (idx_r == '0);
  assign final_res = !sending || (idx_r == desc_r.count - 1'b1);

  always_comb begin
    res                 = '0;
    res.accepted        = desc_r.accepted;
    res.last            = final_res;
    if (sending) begin
      res.send_type       = desc_r.send_type;
      res.send_length     = desc_r.send_length;
      res.echo_identifier = id_r;
      res.echo_sequence   = seq_r;
    end
    if (final_res) begin
      res.timer_request = desc_r.timer_request;
    end
    if (first) begin
      res.deliver_length  = desc_r.deliver_length;
      res.error_code      = desc_r.error_code;
      res.address_value   = desc_r.first_addr;
      res.address_changed = desc_r.address_changed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      id_r        <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (taken) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        desc_r <= q_desc;
        idx_r  <= '0;
        busy_r <= 1'b1;
        if (q_desc.load_ids) begin
          id_r  <= cfg.identifier_start;
          seq_r <= cfg.sequence_start;
        end
      end else if (emit) begin
        out_item_r <= res;
        // Each message sent moves each enabled echo field on by the prime step.
        if (sending && cfg.step_identifier) begin
          id_r <= id_r + itcs_pkg::PRIME_STEP;
        end
        if (sending && cfg.step_sequence) begin
          seq_r <= seq_r + itcs_pkg::PRIME_STEP;
        end
        if (final_res) begin
          busy_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    emit && final_res |=> !busy_r)
    else $error("back end stayed busy after the final beat of an event");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.send_type == itcs_pkg::SEND_NONE |->
      out_item_r.echo_identifier == 16'd0 && out_item_r.echo_sequence == 16'd0)
    else $error("result without a send carries echo fields");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !busy_r)
    else $error("back end not idle after reset");
`endif

endmodule

`default_nettype wire

// ===== hdl/icmp_tunnel_client_session_unit.sv =====
`default_nettype none

// Each event taken goes into the queue; the idle result generator loads it
// into its descriptor register and registers its results one per beat, up
// to POLL_LIMIT, taking no new event until the last. Throughput: one beat
// per cycle while the result register is free; the front end classifies one
// event per cycle into a QUEUE_DEPTH-entry queue while it is not full.
// Reset (rst_n low, synchronous): session closed, configuration and counters
// cleared, client address all ones, queue and result register empty.
module icmp_tunnel_client_session_unit #(
  parameter int CHALLENGE_BYTES = itcs_pkg::CHALLENGE_BYTES_DFLT,
  parameter int RESPONSE_BYTES  = itcs_pkg::RESPONSE_BYTES_DFLT,
  parameter int CONNECT_BYTES   = itcs_pkg::CONNECT_BYTES_DFLT,
  parameter int POLL_LIMIT      = itcs_pkg::POLL_LIMIT_DFLT,
  parameter int QUEUE_DEPTH     = itcs_pkg::QUEUE_DEPTH_DFLT
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_push,
  input  wire itcs_pkg::in_item_t                 in_item,
  output logic                                    in_full,
  input  wire logic                               out_pop,
  output itcs_pkg::out_item_t                     out_item,
  output logic                                    out_empty,
  input  wire logic                               cfg_we,
  input  wire logic [itcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [itcs_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

  itcs_pkg::cfg_t  cfg_r;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  itcs_pkg::desc_t q_din;
  itcs_pkg::desc_t q_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        itcs_pkg::REG_SERVER_ADDRESS:   cfg_r.server_address <= cfg_wr_data;
        itcs_pkg::REG_INITIAL_DESIRED:  cfg_r.initial_desired_address <= cfg_wr_data;
        itcs_pkg::REG_POLL_COUNT:       cfg_r.poll_count <= cfg_wr_data[3:0];
        itcs_pkg::REG_STEP_IDENTIFIER:  cfg_r.step_identifier <= cfg_wr_data[0];
        itcs_pkg::REG_STEP_SEQUENCE:    cfg_r.step_sequence <= cfg_wr_data[0];
        itcs_pkg::REG_IDENTIFIER_START: cfg_r.identifier_start <= cfg_wr_data[15:0];
        itcs_pkg::REG_SEQUENCE_START:   cfg_r.sequence_start <= cfg_wr_data[15:0];
        default: begin
        end
      endcase
    end
  end

  itcs_front #(
    .CHALLENGE_BYTES (CHALLENGE_BYTES),
    .RESPONSE_BYTES  (RESPONSE_BYTES),
    .CONNECT_BYTES   (CONNECT_BYTES),
    .POLL_LIMIT      (POLL_LIMIT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_push  (q_push),
    .q_desc  (q_din),
    .q_full  (q_full)
  );

  itcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  itcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_desc    (q_dout),
    .q_pop     (q_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

`default_nettype wire
